// ----- sv/spc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [3:0] REQ_TICK       = 4'd0;
   localparam logic [3:0] REQ_START      = 4'd1;
   localparam logic [3:0] REQ_STOP       = 4'd2;
   localparam logic [3:0] REQ_PAUSE      = 4'd3;
   localparam logic [3:0] REQ_RESUME     = 4'd4;
   localparam logic [3:0] REQ_STEP_CYC   = 4'd5;
   localparam logic [3:0] REQ_STEP_ABS   = 4'd6;
   localparam logic [3:0] REQ_SET_TIME   = 4'd7;
   localparam logic [3:0] REQ_SET_CORR   = 4'd8;
   localparam logic [3:0] REQ_READ       = 4'd9;

   // Run states reported in the result.
   localparam logic [1:0] RUN_STOPPED = 2'd0;
   localparam logic [1:0] RUN_RUNNING = 2'd1;
   localparam logic [1:0] RUN_PAUSED  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TICK_PERIOD    = 3'd0;
   localparam logic [2:0] CSR_SPEED_RATE     = 3'd1;
   localparam logic [2:0] CSR_ONLINE_MODE    = 3'd2;
   localparam logic [2:0] CSR_SLEW_STEP      = 3'd3;
   localparam logic [2:0] CSR_JUMP_THRESHOLD = 3'd4;

   // Configuration reset values.
   localparam logic [31:0] RST_TICK_PERIOD    = 32'd10000;
   localparam logic [15:0] RST_SPEED_RATE     = 16'd1;
   localparam logic [31:0] RST_SLEW_STEP      = 32'd10000;
   localparam logic [62:0] RST_JUMP_THRESHOLD = 63'd3000000000;

   typedef struct packed {
      logic load;
      logic mul_rate;
      logic mul_lo;
      logic mul_hi;
      logic commit;
   } spc_cmd_type;

endpackage

`default_nettype wire

// ----- sv/spc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spc_ctrl
   import spc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output spc_cmd_type cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_RATE = 3'd1;
   localparam logic [2:0] S_MUL_LO   = 3'd2;
   localparam logic [2:0] S_MUL_HI   = 3'd3;
   localparam logic [2:0] S_EXEC     = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       can_commit;
   logic       req_fire;

   // The output register is free when empty or being drained in this cycle.
   assign can_commit = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_EXEC) && can_commit);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.load     = req_fire;
      cmd.mul_rate = (state_ff == S_MUL_RATE);
      cmd.mul_lo   = (state_ff == S_MUL_LO);
      cmd.mul_hi   = (state_ff == S_MUL_HI);
      cmd.commit   = (state_ff == S_EXEC) && can_commit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_MUL_RATE;
         end
         S_MUL_RATE: state_in = S_MUL_LO;
         S_MUL_LO:   state_in = S_MUL_HI;
         S_MUL_HI:   state_in = S_EXEC;
         S_EXEC: begin
            if (can_commit) state_in = req_fire ? S_MUL_RATE : S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

`ifndef ASSERT_OFF
   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (state_ff == S_IDLE || state_ff == S_EXEC))
      else $error("request accepted while an item is in flight");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_MUL_RATE))
      else $error("accepted request did not start the multiply sequence");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit would overwrite an undelivered result");
   a_seq_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_HI) |-> ($past(state_ff) == S_MUL_LO))
      else $error("multiply sequence skipped a step");
`endif

endmodule

`default_nettype wire

// ----- sv/spc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spc_dp
   import spc_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  spc_cmd_type  cmd,
   input  wire  [3:0]   req_type,
   input  wire  [63:0]  req_value,
   input  wire  [31:0]  req_cycles,
   input  wire          cfg_we,
   input  wire  [2:0]   cfg_index,
   input  wire  [63:0]  cfg_data,
   output logic         out_ok,
   output logic [63:0]  out_time,
   output logic [1:0]   out_state,
   output logic [63:0]  out_pend
);

   // Configuration
   logic [31:0] period_ff;
   logic [15:0] rate_ff;
   logic        online_ff;
   logic [31:0] slew_ff;
   logic [62:0] jump_ff;

   // Architectural state
   logic [1:0]  run_ff;
   logic [63:0] time_ff;
   logic [63:0] pend_ff;
   logic [1:0]  run_in;
   logic [63:0] time_in;
   logic [63:0] pend_in;
   logic        ok_in;

   // Captured request
   logic [3:0]  type_ff;
   logic [63:0] value_ff;
   logic [31:0] cycles_ff;

   // Working registers
   logic [47:0] prod_ff;
   logic [63:0] mag_ff;
   logic [63:0] take_ff;
   logic [63:0] acc_ff;
   logic [63:0] adv_ff;

   logic [15:0]        eff_rate;
   logic [47:0]        prod_in;
   logic [63:0]        mag_in;
   logic [63:0]        take_in;
   logic [63:0]        slew_signed;
   logic signed [64:0] lo_prod;
   logic signed [48:0] hi_prod;

   assign eff_rate = online_ff ? 16'd1 : rate_ff;
   assign prod_in  = {32'd0, eff_rate} * {16'd0, period_ff};
   assign mag_in   = pend_ff[63] ? (64'd0 - pend_ff) : pend_ff;

   // A correction below one slew step or beyond the jump bound goes in whole.
   assign slew_signed = pend_ff[63] ? (64'd0 - {32'd0, slew_ff}) : {32'd0, slew_ff};
   assign take_in = ((mag_ff < {32'd0, slew_ff}) || (mag_ff > {1'b0, jump_ff}))
                    ? pend_ff : slew_signed;

   // rate*period times signed cycles, modulo 2^64, as two partial products.
   assign lo_prod = $signed({1'b0, prod_ff[31:0]}) * $signed(cycles_ff);
   assign hi_prod = $signed({1'b0, prod_ff[47:32]}) * $signed(cycles_ff);

   always_comb begin
      ok_in   = 1'b1;
      run_in  = run_ff;
      time_in = time_ff;
      pend_in = pend_ff;
      unique case (type_ff)
         REQ_TICK: begin
            pend_in = pend_ff - take_ff;
            if (run_ff == RUN_RUNNING) time_in = time_ff + adv_ff;
         end
         REQ_START: begin
            if (run_ff != RUN_PAUSED) time_in = value_ff;
            run_in = RUN_RUNNING;
         end
         REQ_STOP: run_in = RUN_STOPPED;
         REQ_PAUSE: begin
            if (run_ff == RUN_RUNNING) run_in = RUN_PAUSED;
            else ok_in = 1'b0;
         end
         REQ_RESUME: begin
            if (run_ff == RUN_PAUSED) run_in = RUN_RUNNING;
            else ok_in = 1'b0;
         end
         REQ_STEP_CYC: begin
            if (run_ff == RUN_PAUSED) time_in = time_ff + acc_ff;
            else ok_in = 1'b0;
         end
         REQ_STEP_ABS: begin
            if (run_ff == RUN_PAUSED) time_in = value_ff;
            else ok_in = 1'b0;
         end
         REQ_SET_TIME: pend_in = value_ff - time_ff;
         REQ_SET_CORR: pend_in = value_ff;
         REQ_READ: ;
         default: ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= RST_TICK_PERIOD;
         rate_ff   <= RST_SPEED_RATE;
         online_ff <= 1'b0;
         slew_ff   <= RST_SLEW_STEP;
         jump_ff   <= RST_JUMP_THRESHOLD;
         run_ff    <= RUN_STOPPED;
         time_ff   <= 64'd0;
         pend_ff   <= 64'd0;
      end else begin
         if (cfg_we) begin
            unique case (cfg_index)
               CSR_TICK_PERIOD:    period_ff <= cfg_data[31:0];
               CSR_SPEED_RATE:     rate_ff   <= cfg_data[15:0];
               CSR_ONLINE_MODE:    online_ff <= cfg_data[0];
               CSR_SLEW_STEP:      slew_ff   <= cfg_data[31:0];
               CSR_JUMP_THRESHOLD: jump_ff   <= cfg_data[62:0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            run_ff  <= run_in;
            time_ff <= time_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff   <= req_type;
         value_ff  <= req_value;
         cycles_ff <= req_cycles;
      end
      if (cmd.mul_rate) begin
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
      end
      if (cmd.mul_lo) begin
         acc_ff  <= lo_prod[63:0];
         take_ff <= take_in;
      end
      if (cmd.mul_hi) begin
         acc_ff <= acc_ff + {hi_prod[31:0], 32'd0};
         adv_ff <= {16'd0, prod_ff} + take_ff;
      end
      if (cmd.commit) begin
         out_ok    <= ok_in;
         out_time  <= time_in;
         out_state <= run_in;
         out_pend  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/slewed_pausable_clock.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Slewed pausable time-of-day clock in 100 ns units. Each request beat (tick,
// start, stop, pause, resume, step, set target time, set correction, read)
// returns exactly one response beat with an ok flag, the time, the run state
// and the pending correction after the request. An accepted request passes
// through these states before its result is in the output register: MUL_RATE
// forms rate times tick period and the correction magnitude, MUL_LO and MUL_HI
// form the signed cycle-step product as two partial products, and EXEC commits
// the state. The next request is accepted in the commit cycle, so only one
// request is in flight at a time; a response left waiting holds the commit.
// Configuration writes are always ready and must only be issued while no
// request is in flight.
module slewed_pausable_clock
   import spc_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [95:0]  req_tdata,   // value[63:0], cycles[95:64]
   input  wire  [3:0]   req_tuser,   // req_type[3:0]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [135:0] rsp_tdata,   // time_now[63:0], run_state[65:64],
                                     // pending_correction[129:66], zero[135:130]
   output logic         rsp_tuser,   // ok
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [63:0]  csr_data
);

   spc_cmd_type cmd;
   logic        out_ok;
   logic [63:0] out_time;
   logic [1:0]  out_state;
   logic [63:0] out_pend;

   assign csr_ready = 1'b1;

   spc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_type   (req_tuser),
      .req_value  (req_tdata[63:0]),
      .req_cycles (req_tdata[95:64]),
      .cfg_we     (csr_valid && csr_ready),
      .cfg_index  (csr_index),
      .cfg_data   (csr_data),
      .out_ok     (out_ok),
      .out_time   (out_time),
      .out_state  (out_state),
      .out_pend   (out_pend)
   );

   assign rsp_tdata = {6'd0, out_pend, out_state, out_time};
   assign rsp_tuser = out_ok;

endmodule

`default_nettype wire
